/* rtl/t2d_pkg.sv */
// Shared types and constants for the planar bar tangent/force pipeline.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package t2d_pkg;

    // Field and datapath widths
    localparam int LenW     = 34;          // bar length, unsigned Q18.16
    localparam int SumW     = 66;          // dx^2 + dy^2
    localparam int RootBits = 34;          // one root bit per stage
    localparam int RemW     = 70;          // square root remainder
    localparam int DivNumW  = 64;          // divider dividend
    localparam int DivQuoW  = 48;          // divider quotient, one bit per stage
    localparam int DivCmpW  = DivNumW + LenW - 16;  // divisor shifted by up to DivQuoW-1
    localparam int DivLanes = 5;

    // Divider lane assignment
    localparam int LaneTx = 0;
    localparam int LaneTy = 1;
    localparam int LaneQ  = 2;
    localparam int LaneFx = 3;
    localparam int LaneFy = 4;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] axial_stiffness;
        logic signed [31:0] axial_force;
    } item_t;

    typedef struct packed {
        logic        [33:0] bar_length;
        logic signed [31:0] k_xx;
        logic signed [31:0] k_yy;
        logic signed [31:0] k_xy;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic               zero_length;
        logic               saturated;
    } result_t;

    // Side data that rides along the square root stages
    typedef struct packed {
        logic               sx;
        logic               sy;
        logic               sn;
        logic               zero;
        logic signed [31:0] k;
        logic        [32:0] adx;
        logic        [32:0] ady;
        logic        [31:0] an;
        logic        [63:0] pax;
        logic        [63:0] pay;
    } root_sb_t;

    // Side data that rides along the divider stages
    typedef struct packed {
        logic               sx;
        logic               sy;
        logic               sn;
        logic               zero;
        logic signed [31:0] k;
        logic   [LenW-1:0]  len;
    } div_sb_t;

    typedef logic [DivLanes-1:0][DivNumW-1:0] div_num_t;
    typedef logic [DivLanes-1:0][DivQuoW-1:0] div_quo_t;

    // Unsaturated results leaving the tail stages
    typedef struct packed {
        logic   [LenW-1:0]  len;
        logic signed [53:0] kxx;
        logic signed [53:0] kyy;
        logic signed [53:0] kxy;
        logic signed [32:0] fx;
        logic signed [32:0] fy;
        logic               zero;
    } tail_out_t;

endpackage

/* rtl/t2d_sqrt.sv */
// Pipelined integer square root, one root bit resolved per register stage.
// Depends on t2d_pkg; side data travels with each transaction.
`timescale 1ns / 1ps

module t2d_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [t2d_pkg::SumW-1:0]    radicand,
    input  t2d_pkg::root_sb_t           in_sb,
    output logic                        out_valid,
    output logic [t2d_pkg::LenW-1:0]    root,
    output t2d_pkg::root_sb_t           out_sb
);
    import t2d_pkg::*;

    logic [RemW-1:0] rem_w  [0:RootBits];
    logic [LenW-1:0] root_w [0:RootBits];
    root_sb_t        sb_w   [0:RootBits];
    logic            vld_w  [0:RootBits];

    assign rem_w[0]  = RemW'(radicand);
    assign root_w[0] = '0;
    assign sb_w[0]   = in_sb;
    assign vld_w[0]  = in_valid;

    for (genvar s = 0; s < RootBits; s++)
    begin : g_stage
        localparam int B = RootBits - 1 - s;

        logic [RemW-1:0] trial;
        logic            fits;
        logic [RemW-1:0] rem_next;
        logic [LenW-1:0] root_next;
        logic [RemW-1:0] rem_reg;
        logic [LenW-1:0] root_reg;
        root_sb_t        sb_reg;
        logic            vld_reg;

        // (r + 2^B)^2 - r^2 against the running remainder
        always_comb
        begin
            trial     = (RemW'(root_w[s]) << (B + 1)) | (RemW'(1) << (2 * B));
            fits      = (trial <= rem_w[s]);
            rem_next  = fits ? (rem_w[s] - trial) : rem_w[s];
            root_next = fits ? (root_w[s] | (LenW'(1) << B)) : root_w[s];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else if (en)
                vld_reg <= vld_w[s];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= rem_next;
                root_reg <= root_next;
                sb_reg   <= sb_w[s];
            end
        end

        assign rem_w[s+1]  = rem_reg;
        assign root_w[s+1] = root_reg;
        assign sb_w[s+1]   = sb_reg;
        assign vld_w[s+1]  = vld_reg;
    end

    assign out_valid = vld_w[RootBits];
    assign root      = root_w[RootBits];
    assign out_sb    = sb_w[RootBits];

endmodule

/* rtl/t2d_div.sv */
// Pipelined restoring divider, several dividend lanes over one shared divisor.
// Depends on t2d_pkg; the divisor is the bar length carried in the side data.
`timescale 1ns / 1ps

module t2d_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  t2d_pkg::div_num_t   num,
    input  t2d_pkg::div_sb_t    in_sb,
    output logic                out_valid,
    output t2d_pkg::div_quo_t   quo,
    output t2d_pkg::div_sb_t    out_sb
);
    import t2d_pkg::*;

    div_num_t rem_w [0:DivQuoW];
    div_quo_t quo_w [0:DivQuoW];
    div_sb_t  sb_w  [0:DivQuoW];
    logic     vld_w [0:DivQuoW];

    assign rem_w[0] = num;
    assign quo_w[0] = '0;
    assign sb_w[0]  = in_sb;
    assign vld_w[0] = in_valid;

    for (genvar s = 0; s < DivQuoW; s++)
    begin : g_stage
        localparam int I = DivQuoW - 1 - s;

        logic [DivCmpW-1:0] shifted;
        div_num_t           rem_next;
        div_quo_t           quo_next;
        div_num_t           rem_reg;
        div_quo_t           quo_reg;
        div_sb_t            sb_reg;
        logic               vld_reg;

        // One quotient bit per lane: subtract divisor * 2^I when it fits
        always_comb
        begin
            shifted = DivCmpW'(sb_w[s].len) << I;
            for (int l = 0; l < DivLanes; l++)
            begin
                if (DivCmpW'(rem_w[s][l]) >= shifted)
                begin
                    rem_next[l] = rem_w[s][l] - shifted[DivNumW-1:0];
                    quo_next[l] = quo_w[s][l] | (DivQuoW'(1) << I);
                end
                else
                begin
                    rem_next[l] = rem_w[s][l];
                    quo_next[l] = quo_w[s][l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else if (en)
                vld_reg <= vld_w[s];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                sb_reg  <= sb_w[s];
            end
        end

        assign rem_w[s+1] = rem_reg;
        assign quo_w[s+1] = quo_reg;
        assign sb_w[s+1]  = sb_reg;
        assign vld_w[s+1] = vld_reg;
    end

    assign out_valid = vld_w[DivQuoW];
    assign quo       = quo_w[DivQuoW];
    assign out_sb    = sb_w[DivQuoW];

endmodule

/* rtl/t2d_tail.sv */
// Tail stages: direction products, N/L scaling and the Q.30 tangent products.
// Depends on t2d_pkg; fed by the divider, feeds the saturating output stage.
`timescale 1ns / 1ps

module t2d_tail (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  t2d_pkg::div_quo_t   quo,
    input  t2d_pkg::div_sb_t    in_sb,
    output logic                out_valid,
    output t2d_pkg::tail_out_t  out_data
);
    import t2d_pkg::*;

    // ---------------- stage 1: t products, q = N/L, a = k - q
    logic        [30:0] txm;
    logic        [30:0] tym;
    logic        [47:0] qm;
    logic        [61:0] prod_xx;
    logic        [61:0] prod_yy;
    logic        [61:0] prod_xy;
    logic signed [50:0] kx;
    logic signed [50:0] qx;
    logic signed [48:0] q_next;
    logic signed [50:0] a_next;

    logic        [30:0] txx_reg, tyy_reg, txy_reg;
    logic               sxy_reg;
    logic signed [48:0] q1_reg;
    logic signed [50:0] a_reg;
    logic        [31:0] fxm1_reg, fym1_reg;
    logic               sfx1_reg, sfy1_reg, zero1_reg;
    logic   [LenW-1:0]  len1_reg;
    logic               vld1_reg;

    always_comb
    begin
        txm     = quo[LaneTx][30:0];
        tym     = quo[LaneTy][30:0];
        qm      = quo[LaneQ];
        prod_xx = 62'(txm) * 62'(txm);
        prod_yy = 62'(tym) * 62'(tym);
        prod_xy = 62'(txm) * 62'(tym);
        kx      = 51'(in_sb.k);
        qx      = $signed(51'(qm));
        q_next  = in_sb.sn ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
        a_next  = in_sb.sn ? (kx + qx) : (kx - qx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld1_reg <= 1'b0;
        else if (en)
            vld1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            txx_reg   <= prod_xx[60:30];
            tyy_reg   <= prod_yy[60:30];
            txy_reg   <= prod_xy[60:30];
            sxy_reg   <= in_sb.sx ^ in_sb.sy;
            q1_reg    <= q_next;
            a_reg     <= a_next;
            fxm1_reg  <= quo[LaneFx][31:0];
            fym1_reg  <= quo[LaneFy][31:0];
            sfx1_reg  <= in_sb.sn ^ in_sb.sx;
            sfy1_reg  <= in_sb.sn ^ in_sb.sy;
            zero1_reg <= in_sb.zero;
            len1_reg  <= in_sb.len;
        end
    end

    // ---------------- stage 2: |a| split into partial products
    logic        [50:0] a_abs;
    logic        [25:0] a_hi;
    logic        [23:0] a_lo;

    logic        [56:0] phi_xx_reg, phi_yy_reg, phi_xy_reg;
    logic        [54:0] plo_xx_reg, plo_yy_reg, plo_xy_reg;
    logic               neg_d_reg, neg_x_reg;
    logic signed [48:0] q2_reg;
    logic        [31:0] fxm2_reg, fym2_reg;
    logic               sfx2_reg, sfy2_reg, zero2_reg;
    logic   [LenW-1:0]  len2_reg;
    logic               vld2_reg;

    always_comb
    begin
        a_abs = a_reg[50] ? 51'(-a_reg) : 51'(a_reg);
        a_hi  = a_abs[49:24];
        a_lo  = a_abs[23:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld2_reg <= 1'b0;
        else if (en)
            vld2_reg <= vld1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            phi_xx_reg <= 57'(a_hi) * 57'(txx_reg);
            phi_yy_reg <= 57'(a_hi) * 57'(tyy_reg);
            phi_xy_reg <= 57'(a_hi) * 57'(txy_reg);
            plo_xx_reg <= 55'(a_lo) * 55'(txx_reg);
            plo_yy_reg <= 55'(a_lo) * 55'(tyy_reg);
            plo_xy_reg <= 55'(a_lo) * 55'(txy_reg);
            neg_d_reg  <= a_reg[50];
            neg_x_reg  <= a_reg[50] ^ sxy_reg;
            q2_reg     <= q1_reg;
            fxm2_reg   <= fxm1_reg;
            fym2_reg   <= fym1_reg;
            sfx2_reg   <= sfx1_reg;
            sfy2_reg   <= sfy1_reg;
            zero2_reg  <= zero1_reg;
            len2_reg   <= len1_reg;
        end
    end

    // ---------------- stage 3: recombine partial products, drop 30 bits
    logic        [55:0] low_xx, low_yy, low_xy;

    logic        [51:0] r_xx_reg, r_yy_reg, r_xy_reg;
    logic               neg_d3_reg, neg_x3_reg;
    logic signed [48:0] q3_reg;
    logic signed [32:0] fx3_reg, fy3_reg;
    logic               zero3_reg;
    logic   [LenW-1:0]  len3_reg;
    logic               vld3_reg;

    always_comb
    begin
        low_xx = 56'({phi_xx_reg[5:0], 24'b0}) + 56'(plo_xx_reg);
        low_yy = 56'({phi_yy_reg[5:0], 24'b0}) + 56'(plo_yy_reg);
        low_xy = 56'({phi_xy_reg[5:0], 24'b0}) + 56'(plo_xy_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld3_reg <= 1'b0;
        else if (en)
            vld3_reg <= vld2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_xx_reg   <= 52'(phi_xx_reg[56:6]) + 52'(low_xx[55:30]);
            r_yy_reg   <= 52'(phi_yy_reg[56:6]) + 52'(low_yy[55:30]);
            r_xy_reg   <= 52'(phi_xy_reg[56:6]) + 52'(low_xy[55:30]);
            neg_d3_reg <= neg_d_reg;
            neg_x3_reg <= neg_x_reg;
            q3_reg     <= q2_reg;
            fx3_reg    <= sfx2_reg ? -$signed({1'b0, fxm2_reg}) : $signed({1'b0, fxm2_reg});
            fy3_reg    <= sfy2_reg ? -$signed({1'b0, fym2_reg}) : $signed({1'b0, fym2_reg});
            zero3_reg  <= zero2_reg;
            len3_reg   <= len2_reg;
        end
    end

    // ---------------- stage 4: apply sign, add N/L on the diagonal
    logic signed [53:0] rx_xx, rx_yy, rx_xy, q54;
    tail_out_t          out_reg;
    logic               vld4_reg;

    always_comb
    begin
        rx_xx = $signed(54'(r_xx_reg));
        rx_yy = $signed(54'(r_yy_reg));
        rx_xy = $signed(54'(r_xy_reg));
        q54   = 54'(q3_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld4_reg <= 1'b0;
        else if (en)
            vld4_reg <= vld3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.len  <= len3_reg;
            out_reg.kxx  <= neg_d3_reg ? (q54 - rx_xx) : (q54 + rx_xx);
            out_reg.kyy  <= neg_d3_reg ? (q54 - rx_yy) : (q54 + rx_yy);
            out_reg.kxy  <= neg_x3_reg ? -rx_xy : rx_xy;
            out_reg.fx   <= fx3_reg;
            out_reg.fy   <= fy3_reg;
            out_reg.zero <= zero3_reg;
        end
    end

    assign out_valid = vld4_reg;
    assign out_data  = out_reg;

endmodule

/* rtl/truss2d_tangent_and_force.sv */
// Planar two-node bar: length, tangent stiffness entries and nodal force, one
// transaction per cycle. The pipeline has three input stages (differences,
// squares, sum), 34 square root stages, 48 divider stages shared by the five
// quotients, four tail stages and the saturating output register. The whole
// pipeline advances together; it holds only while a finished result is stalled.
// Depends on t2d_pkg, t2d_sqrt, t2d_div and t2d_tail.
`timescale 1ns / 1ps

module truss2d_tangent_and_force (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  t2d_pkg::item_t      item,
    output logic                result_valid,
    input  logic                result_stall,
    output t2d_pkg::result_t    result
);
    import t2d_pkg::*;

    logic adv;
    logic result_valid_reg;

    // Pipeline advances unless the output register holds a stalled result
    assign adv        = !(result_valid_reg && result_stall);
    assign item_stall = !adv;

    // ---------------- stage 1: differences and magnitudes
    logic signed [32:0] dx, dy;
    logic        [32:0] adx1_reg, ady1_reg;
    logic        [31:0] an1_reg;
    logic               sx1_reg, sy1_reg, sn1_reg, zero1_reg;
    logic signed [31:0] k1_reg;
    logic               vld1_reg;

    always_comb
    begin
        dx = 33'(item.end_x) - 33'(item.start_x);
        dy = 33'(item.end_y) - 33'(item.start_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld1_reg <= 1'b0;
        else if (adv)
            vld1_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            adx1_reg  <= dx[32] ? 33'(-dx) : 33'(dx);
            ady1_reg  <= dy[32] ? 33'(-dy) : 33'(dy);
            an1_reg   <= item.axial_force[31] ? 32'(-item.axial_force)
                                              : 32'(item.axial_force);
            sx1_reg   <= dx[32];
            sy1_reg   <= dy[32];
            sn1_reg   <= item.axial_force[31];
            zero1_reg <= (dx == 33'sd0) && (dy == 33'sd0);
            k1_reg    <= item.axial_stiffness;
        end
    end

    // ---------------- stage 2: squares and force numerators
    logic [SumW-1:0] sqx2_reg, sqy2_reg;
    root_sb_t        sb2_reg;
    logic            vld2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld2_reg <= 1'b0;
        else if (adv)
            vld2_reg <= vld1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqx2_reg     <= SumW'(adx1_reg) * SumW'(adx1_reg);
            sqy2_reg     <= SumW'(ady1_reg) * SumW'(ady1_reg);
            sb2_reg.sx   <= sx1_reg;
            sb2_reg.sy   <= sy1_reg;
            sb2_reg.sn   <= sn1_reg;
            sb2_reg.zero <= zero1_reg;
            sb2_reg.k    <= k1_reg;
            sb2_reg.adx  <= adx1_reg;
            sb2_reg.ady  <= ady1_reg;
            sb2_reg.an   <= an1_reg;
            sb2_reg.pax  <= 64'(an1_reg) * 64'(adx1_reg);
            sb2_reg.pay  <= 64'(an1_reg) * 64'(ady1_reg);
        end
    end

    // ---------------- stage 3: radicand
    logic [SumW-1:0] sum3_reg;
    root_sb_t        sb3_reg;
    logic            vld3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld3_reg <= 1'b0;
        else if (adv)
            vld3_reg <= vld2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum3_reg <= sqx2_reg + sqy2_reg;
            sb3_reg  <= sb2_reg;
        end
    end

    // ---------------- square root
    logic            root_vld;
    logic [LenW-1:0] root_len;
    root_sb_t        root_sb;

    t2d_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (vld3_reg),
        .radicand  (sum3_reg),
        .in_sb     (sb3_reg),
        .out_valid (root_vld),
        .root      (root_len),
        .out_sb    (root_sb)
    );

    // ---------------- divisions by the length
    div_num_t div_num;
    div_sb_t  div_in_sb;
    logic     div_vld;
    div_quo_t div_quo;
    div_sb_t  div_out_sb;

    always_comb
    begin
        div_num[LaneTx] = DivNumW'(root_sb.adx) << 30;
        div_num[LaneTy] = DivNumW'(root_sb.ady) << 30;
        div_num[LaneQ]  = DivNumW'(root_sb.an) << 16;
        div_num[LaneFx] = root_sb.pax;
        div_num[LaneFy] = root_sb.pay;
        div_in_sb.sx    = root_sb.sx;
        div_in_sb.sy    = root_sb.sy;
        div_in_sb.sn    = root_sb.sn;
        div_in_sb.zero  = root_sb.zero;
        div_in_sb.k     = root_sb.k;
        div_in_sb.len   = root_len;
    end

    t2d_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (root_vld),
        .num       (div_num),
        .in_sb     (div_in_sb),
        .out_valid (div_vld),
        .quo       (div_quo),
        .out_sb    (div_out_sb)
    );

    // ---------------- tangent and force arithmetic
    logic      tail_vld;
    tail_out_t tail_data;

    t2d_tail u_tail (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (div_vld),
        .quo       (div_quo),
        .in_sb     (div_out_sb),
        .out_valid (tail_vld),
        .out_data  (tail_data)
    );

    // ---------------- output register: saturate, zero-length override
    logic               ovf_xx, ovf_yy, ovf_xy, ovf_fx, ovf_fy;
    logic signed [31:0] c_xx, c_yy, c_xy, c_fx, c_fy;
    result_t            result_next;
    result_t            result_reg;

    always_comb
    begin
        ovf_xx = (tail_data.kxx[53:31] != {23{tail_data.kxx[31]}});
        ovf_yy = (tail_data.kyy[53:31] != {23{tail_data.kyy[31]}});
        ovf_xy = (tail_data.kxy[53:31] != {23{tail_data.kxy[31]}});
        ovf_fx = (tail_data.fx[32] != tail_data.fx[31]);
        ovf_fy = (tail_data.fy[32] != tail_data.fy[31]);
        c_xx = ovf_xx ? (tail_data.kxx[53] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                      : tail_data.kxx[31:0];
        c_yy = ovf_yy ? (tail_data.kyy[53] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                      : tail_data.kyy[31:0];
        c_xy = ovf_xy ? (tail_data.kxy[53] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                      : tail_data.kxy[31:0];
        c_fx = ovf_fx ? (tail_data.fx[32] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                      : tail_data.fx[31:0];
        c_fy = ovf_fy ? (tail_data.fy[32] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                      : tail_data.fy[31:0];

        if (tail_data.zero)
        begin
            result_next             = '0;
            result_next.zero_length = 1'b1;
        end
        else
        begin
            result_next.bar_length  = tail_data.len;
            result_next.k_xx        = c_xx;
            result_next.k_yy        = c_yy;
            result_next.k_xy        = c_xy;
            result_next.force_x     = c_fx;
            result_next.force_y     = c_fy;
            result_next.zero_length = 1'b0;
            result_next.saturated   = ovf_xx | ovf_yy | ovf_xy | ovf_fx | ovf_fy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (adv)
            result_valid_reg <= tail_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ---------------- checks
    logic u_tail_vld_probe;
    assign u_tail_vld_probe = tail_vld;

    // Coincident nodes clear every other field
    a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.zero_length) |->
            (result.bar_length == '0 && result.k_xx == '0 && result.k_yy == '0 &&
             result.k_xy == '0 && result.force_x == '0 && result.force_y == '0 &&
             !result.saturated))
        else $error("zero-length transaction carries nonzero fields");

    // Distinct nodes are at least one LSB apart
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.zero_length) |-> (result.bar_length != '0))
        else $error("nonzero element reported with zero length");

    // Nothing moves in the pipeline while the output is held
    a_hold_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> $stable(u_tail_vld_probe))
        else $error("tail advanced during output stall");

endmodule
